[hdl/nlpe_pkg.sv]
// ----------------------------------------------------------------------------
// nlpe_pkg
// Shared types, opcodes and saturation helpers for the nonlocal projection
// energy block.
// ----------------------------------------------------------------------------
package nlpe_pkg;

  // Default number of fractional bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 22;

  // One plane-wave term
  typedef struct packed {
    logic signed [23:0] coef_re;
    logic signed [23:0] coef_im;
    logic signed [23:0] proj;
    logic signed [23:0] phase_re;
    logic signed [23:0] phase_im;
    logic        [22:0] occupation;
    logic signed [23:0] channel_weight;
    logic               last_term;
    logic               last_state;
    logic               start_total;
  } nlpe_in_t;

  // One finished projection
  typedef struct packed {
    logic signed [47:0] fnl_re;
    logic signed [47:0] fnl_im;
    logic signed [63:0] energy_total;
    logic               channel_done;
  } nlpe_out_t;

  // Multiply operations, in issue order
  typedef enum logic [3:0] {
    OP_TR  = 4'd0,  // proj * phase_re
    OP_TI  = 4'd1,  // proj * phase_im (negated)
    OP_RR  = 4'd2,  // coef_re * t_re
    OP_RI  = 4'd3,  // coef_im * t_im, closes dot_re
    OP_IR  = 4'd4,  // coef_re * t_im
    OP_II  = 4'd5,  // coef_im * t_re, closes dot_im
    OP_PRE = 4'd6,  // fnl_re squared
    OP_PIM = 4'd7,  // fnl_im squared, forms |p|^2
    OP_OCC = 4'd8,  // occupation * |p|^2 into channel sum
    OP_WT  = 4'd9   // weight * channel sum into energy total
  } op_e;

  // Controller states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_FIN   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;   // capture a new request
    logic       setup;  // latch operand magnitudes, preload rounding bias
    logic       mul;    // accumulate one 32x32 partial product
    logic [1:0] pp;     // partial product select
    logic       fin;    // shift, saturate and sign the product
    logic       apply;  // fold the product into the state
    logic       emit;   // load the output register
    op_e        op;
  } nlpe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_term;
    logic last_state;
  } nlpe_sts_t;

  // Saturating 64-bit add
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  // Saturate a 66-bit signed value to 48 bits
  function automatic logic [47:0] sat48(input logic [65:0] v);
    if (v[65:47] == '0 || v[65:47] == '1) begin
      sat48 = v[47:0];
    end else begin
      sat48 = v[65] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
  endfunction

  // Magnitude of a signed 64-bit value
  function automatic logic [63:0] abs64(input logic [63:0] a);
    abs64 = a[63] ? (~a + 64'd1) : a;
  endfunction

endpackage

[hdl/nlpe_ctrl.sv]
// ----------------------------------------------------------------------------
// nlpe_ctrl
// Sequencer: walks each request through the multiply operations on the
// shared multiplier and hands finished projections to the output register.
// ----------------------------------------------------------------------------
module nlpe_ctrl import nlpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  nlpe_sts_t  sts_i,
  output nlpe_cmd_t  cmd_o
);

  state_e     state_q, state_d;
  op_e        op_q, op_d;
  logic [1:0] pp_q, pp_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       taken;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign taken  = out_valid_q && !out_stall_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pp_d        = pp_q;
    out_valid_d = out_valid_q && !taken;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.pp    = pp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          op_d       = OP_TR;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        pp_d        = 2'd0;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        pp_d      = pp_q + 2'd1;
        if (pp_q == 2'd3) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_SETUP;
        case (op_q)
          OP_II: begin
            if (sts_i.last_term) begin
              op_d = OP_PRE;
            end else begin
              state_d = ST_IDLE;
            end
          end
          OP_OCC: begin
            if (sts_i.last_state) begin
              op_d = OP_WT;
            end else begin
              state_d = ST_OUT;
            end
          end
          OP_WT: begin
            state_d = ST_OUT;
          end
          default: begin
            op_d = op_e'(op_q + 4'd1);
          end
        endcase
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_TR;
      pp_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pp_q        <= pp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/nlpe_dp.sv]
// ----------------------------------------------------------------------------
// nlpe_dp
// Datapath: captured request, shared 64x64 multiplier built from four 32x32
// partial products, rounding and saturation, and the accumulator state.
// ----------------------------------------------------------------------------
module nlpe_dp import nlpe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  nlpe_in_t   in_item_i,
  input  nlpe_cmd_t  cmd_i,
  output nlpe_sts_t  sts_o,
  output nlpe_out_t  out_item_o
);

  localparam logic [127:0] Half = 128'd1 << (FRAC_BITS - 1);

  nlpe_in_t     item_q;
  logic [63:0]  tr_q, ti_q, tmp_q, pw_q, res_q;
  logic [47:0]  dot_re_q, dot_im_q, fr_q, fi_q;
  logic [63:0]  cs_q, en_q;
  logic [63:0]  mag_a_q, mag_b_q;
  logic         neg_q;
  logic [127:0] acc_q;
  nlpe_out_t    out_q;

  logic [63:0]  opa, opb;
  logic [31:0]  pa, pb;
  logic [63:0]  pprod;
  logic [6:0]   shamt;
  logic [127:0] quot;
  logic [63:0]  qmag, rnd;
  logic         ovf;
  logic [47:0]  dot_im_new;

  // operand select
  always_comb begin
    case (cmd_i.op)
      OP_TR:   begin opa = 64'(item_q.proj);    opb = 64'(item_q.phase_re); end
      OP_TI:   begin opa = 64'(item_q.proj);    opb = 64'(item_q.phase_im); end
      OP_RR:   begin opa = 64'(item_q.coef_re); opb = tr_q; end
      OP_RI:   begin opa = 64'(item_q.coef_im); opb = ti_q; end
      OP_IR:   begin opa = 64'(item_q.coef_re); opb = ti_q; end
      OP_II:   begin opa = 64'(item_q.coef_im); opb = tr_q; end
      OP_PRE:  begin opa = 64'(signed'(fr_q));  opb = 64'(signed'(fr_q)); end
      OP_PIM:  begin opa = 64'(signed'(fi_q));  opb = 64'(signed'(fi_q)); end
      OP_OCC:  begin opa = {41'd0, item_q.occupation}; opb = pw_q; end
      OP_WT:   begin opa = 64'(item_q.channel_weight); opb = cs_q; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // one 32x32 partial product per cycle
  assign pa    = cmd_i.pp[0] ? mag_a_q[63:32] : mag_a_q[31:0];
  assign pb    = cmd_i.pp[1] ? mag_b_q[63:32] : mag_b_q[31:0];
  assign pprod = {32'd0, pa} * {32'd0, pb};
  assign shamt = {cmd_i.pp[0] & cmd_i.pp[1], cmd_i.pp[0] ^ cmd_i.pp[1], 5'd0};

  // round (bias already in acc), saturate, apply sign
  assign quot = acc_q >> FRAC_BITS;
  assign qmag = quot[63:0];
  assign ovf  = (quot[127:64] != '0) ||
                (neg_q ? (qmag > {1'b1, 63'd0}) : qmag[63]);
  always_comb begin
    if (ovf) begin
      rnd = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      rnd = neg_q ? (~qmag + 64'd1) : qmag;
    end
  end

  assign dot_im_new = sat48({{18{dot_im_q[47]}}, dot_im_q} + {{2{tmp_q[63]}}, tmp_q}
                            + {{2{res_q[63]}}, res_q});

  // multiplier registers and captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.setup) begin
      mag_a_q <= abs64(opa);
      mag_b_q <= abs64(opb);
      neg_q   <= opa[63] ^ opb[63];
      acc_q   <= Half;
    end
    if (cmd_i.mul) begin
      acc_q <= acc_q + ({64'd0, pprod} << shamt);
    end
    if (cmd_i.fin) begin
      res_q <= rnd;
    end
    if (cmd_i.emit) begin
      out_q.fnl_re       <= fr_q;
      out_q.fnl_im       <= fi_q;
      out_q.energy_total <= en_q;
      out_q.channel_done <= item_q.last_state;
    end
  end

  // intermediate terms
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      case (cmd_i.op)
        OP_TR:  tr_q  <= res_q;
        OP_TI:  ti_q  <= ~res_q + 64'd1;
        OP_RR:  tmp_q <= res_q;
        OP_IR:  tmp_q <= res_q;
        OP_II: begin
          if (item_q.last_term) begin
            fr_q <= dot_re_q;
            fi_q <= dot_im_new;
          end
        end
        OP_PRE: tmp_q <= res_q;
        OP_PIM: pw_q  <= sat_add64(tmp_q, res_q);
        default: ;
      endcase
    end
  end

  // accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_re_q <= '0;
      dot_im_q <= '0;
      cs_q     <= '0;
      en_q     <= '0;
    end else begin
      if (cmd_i.load && in_item_i.start_total) begin
        en_q <= '0;
      end
      if (cmd_i.apply) begin
        case (cmd_i.op)
          OP_RI: begin
            dot_re_q <= sat48({{18{dot_re_q[47]}}, dot_re_q} + {{2{tmp_q[63]}}, tmp_q}
                              - {{2{res_q[63]}}, res_q});
          end
          OP_II: begin
            if (item_q.last_term) begin
              dot_re_q <= '0;
              dot_im_q <= '0;
            end else begin
              dot_im_q <= dot_im_new;
            end
          end
          OP_OCC: cs_q <= sat_add64(cs_q, res_q);
          OP_WT: begin
            en_q <= sat_add64(en_q, res_q);
            cs_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign sts_o.last_term  = item_q.last_term;
  assign sts_o.last_state = item_q.last_state;
  assign out_item_o       = out_q;

endmodule

[hdl/nonlocal_projection_energy.sv]
// ----------------------------------------------------------------------------
// nonlocal_projection_energy
// Fixed-point nonlocal projection and energy accumulator over a stream of
// plane-wave terms; emits each finished projection with the running total.
// ----------------------------------------------------------------------------
// Each request runs its multiplies in turn on one shared 64x64 multiplier
// (operand setup, four 32x32 partial products, then rounding and update).
// Plain term: six multiplies; a state's last term nine, a channel's last ten.
// A result waits in the output register while the next request is accepted.
// Reset clears the projection, channel and energy sums and all control state.
module nonlocal_projection_energy import nlpe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  nlpe_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output nlpe_out_t out_item_o
);

  nlpe_cmd_t cmd;
  nlpe_sts_t sts;

  // sequencer
  nlpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  nlpe_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule
